/* src/oaid_pkg.sv */
// Shared constants, codes and types for the ordered array insert/delete unit.
// No dependencies; every other file in src imports this package.
package oaid_pkg;

    localparam int CAPACITY = 64;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int INDEX_W  = 6;
    localparam int FILL_W   = 7;
    localparam int POS_W    = 7;
    localparam int DATA_W   = 32;

    typedef enum logic [1:0] {
        FN_APPEND = 2'd0,
        FN_INSERT = 2'd1,
        FN_DELETE = 2'd2,
        FN_LIST   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    // Per-cycle command broadcast to every cell of the chain
    typedef enum logic [2:0] {
        CMD_HOLD   = 3'd0,
        CMD_APPEND = 3'd1,
        CMD_INSERT = 3'd2,
        CMD_DELETE = 3'd3,
        CMD_ROTATE = 3'd4
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic [SLOT_W-1:0]  sel;
        logic [DATA_W-1:0]  value;
    } cell_ctrl_t;

    typedef struct packed {
        status_t             status;
        logic [INDEX_W-1:0]  index;
        logic [DATA_W-1:0]   entry;
        logic [FILL_W-1:0]   fill_count;
        logic                last;
    } rsp_t;

endpackage

/* src/oaid_cell.sv */
// One storage cell of the ordered list chain: holds one entry and trades it
// with its neighbors under the broadcast command. Depends on oaid_pkg.
module oaid_cell
    import oaid_pkg::*;
(
    input  logic               clk,
    input  cell_ctrl_t         ctrl,
    input  logic [SLOT_W-1:0]  slot,
    input  logic [DATA_W-1:0]  left_val,
    input  logic [DATA_W-1:0]  right_val,
    input  logic [DATA_W-1:0]  head_val,
    output logic [DATA_W-1:0]  val
);

    logic [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        case (ctrl.cmd)
            CMD_APPEND:
            begin
                if (slot == ctrl.sel)
                    val_next = ctrl.value;
            end
            CMD_INSERT:
            begin
                // open a gap at sel, take the left neighbor above it
                if (slot == ctrl.sel)
                    val_next = ctrl.value;
                else if (slot > ctrl.sel)
                    val_next = left_val;
            end
            CMD_DELETE:
            begin
                if (slot >= ctrl.sel)
                    val_next = right_val;
            end
            CMD_ROTATE:
            begin
                // wrap the head entry into the last occupied slot
                if (slot == ctrl.sel)
                    val_next = head_val;
                else
                    val_next = right_val;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign val = val_reg;

endmodule

/* src/ordered_array_insert_delete_unit.sv */
// Ordered array insert/delete unit: append, insert, delete take one beat and
// give one result beat through the registered result queue; one edit per cycle
// while the result side keeps up (a full two-beat result queue stalls commands).
// A list of n entries gives n result beats, one per cycle while the queue
// has room; the command side stays stalled while the walk emits entries 1 to
// n-1. Cell 0 is read as the chain rotates by one slot. Reset (rst_n, async
// low) clears the fill count and control; entries stay undefined, no clearing.
module ordered_array_insert_delete_unit
    import oaid_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // command channel
    input  logic                cmd_valid,
    output logic                cmd_stall,
    input  logic [1:0]          func,
    input  logic [POS_W-1:0]    position,
    input  logic signed [DATA_W-1:0] value,
    // response channel
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [1:0]          status,
    output logic [INDEX_W-1:0]  index,
    output logic signed [DATA_W-1:0] entry,
    output logic [FILL_W-1:0]   fill_count,
    output logic                last
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LIST = 2'b10
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [SLOT_W-1:0]  list_idx_reg, list_idx_next;

    // two-deep result queue: head register feeds the ports, skid catches a
    // beat that arrives while the head is stalled
    rsp_t   head_reg, head_next;
    rsp_t   skid_reg;
    logic   head_valid_reg, head_valid_next;
    logic   skid_valid_reg, skid_valid_next;

    rsp_t        push_rsp;
    logic        push;
    logic        pop;
    logic        room;
    logic        accept;
    cell_ctrl_t  ctrl;

    logic [DATA_W-1:0] cell_val [CAPACITY];

    logic               is_full;
    logic               is_empty;
    logic [SLOT_W-1:0]  last_slot;
    logic               list_last;

    assign accept    = cmd_valid && !cmd_stall;
    assign pop       = head_valid_reg && !rsp_stall;
    assign room      = !skid_valid_reg;
    assign cmd_stall = (state_reg != S_IDLE) || skid_valid_reg;

    assign is_full   = (count_reg == CNT_W'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign last_slot = SLOT_W'(count_reg - CNT_W'(1));
    assign list_last = (list_idx_reg == last_slot);

    //------------------------------------------------------------------
    // Command decode and list sequencing
    //------------------------------------------------------------------
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        list_idx_next = list_idx_reg;
        push          = 1'b0;

        ctrl.cmd   = CMD_HOLD;
        ctrl.sel   = count_reg[SLOT_W-1:0];
        ctrl.value = value;

        push_rsp.status     = ST_OK;
        push_rsp.index      = '0;
        push_rsp.entry      = '0;
        push_rsp.fill_count = '0;
        push_rsp.last       = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    push = 1'b1;
                    unique case (func_t'(func))
                        FN_APPEND:
                        begin
                            if (is_full)
                                push_rsp.status = ST_FULL;
                            else
                            begin
                                ctrl.cmd   = CMD_APPEND;
                                ctrl.sel   = count_reg[SLOT_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FN_INSERT:
                        begin
                            // full check wins over the position check
                            if (is_full)
                                push_rsp.status = ST_FULL;
                            else if (32'(position) > 32'(count_reg))
                                push_rsp.status = ST_BADPOS;
                            else
                            begin
                                ctrl.cmd   = CMD_INSERT;
                                ctrl.sel   = position[SLOT_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FN_DELETE:
                        begin
                            // empty check wins over the position check
                            if (is_empty)
                                push_rsp.status = ST_EMPTY;
                            else if (32'(position) >= 32'(count_reg))
                                push_rsp.status = ST_BADPOS;
                            else
                            begin
                                ctrl.cmd   = CMD_DELETE;
                                ctrl.sel   = position[SLOT_W-1:0];
                                count_next = count_reg - CNT_W'(1);
                            end
                        end
                        FN_LIST:
                        begin
                            if (is_empty)
                                push_rsp.status = ST_EMPTY;
                            else
                            begin
                                // emit entry 0 now, rotate, walk the rest
                                push_rsp.entry = cell_val[0];
                                push_rsp.last  = (count_reg == CNT_W'(1));
                                ctrl.cmd       = CMD_ROTATE;
                                ctrl.sel       = last_slot;
                                if (count_reg != CNT_W'(1))
                                begin
                                    state_next    = S_LIST;
                                    list_idx_next = SLOT_W'(1);
                                end
                            end
                        end
                        default:
                        begin
                            push_rsp.status = ST_BADPOS;
                        end
                    endcase
                end
            end
            S_LIST:
            begin
                // advance one entry per cycle while the queue has room
                if (room)
                begin
                    push           = 1'b1;
                    push_rsp.index = INDEX_W'(list_idx_reg);
                    push_rsp.entry = cell_val[0];
                    push_rsp.last  = list_last;
                    ctrl.cmd       = CMD_ROTATE;
                    ctrl.sel       = last_slot;
                    list_idx_next  = list_idx_reg + SLOT_W'(1);
                    if (list_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        push_rsp.fill_count = FILL_W'(count_next);
    end

    //------------------------------------------------------------------
    // Cell chain: each cell sees both neighbors and the head entry
    //------------------------------------------------------------------
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_in;
        logic [DATA_W-1:0] right_in;

        if (g == 0)
        begin : g_first
            assign left_in = '0;
        end
        else
        begin : g_mid_left
            assign left_in = cell_val[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_end
            assign right_in = '0;
        end
        else
        begin : g_mid_right
            assign right_in = cell_val[g+1];
        end

        oaid_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .slot      (SLOT_W'(g)),
            .left_val  (left_in),
            .right_val (right_in),
            .head_val  (cell_val[0]),
            .val       (cell_val[g])
        );
    end

    //------------------------------------------------------------------
    // Result queue
    //------------------------------------------------------------------
    always_comb
    begin
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        // push only happens with the skid empty
        skid_valid_next = skid_valid_reg ? !pop : (push && head_valid_reg && !pop);
        if (!head_valid_reg || pop)
        begin
            head_next       = skid_valid_reg ? skid_reg : push_rsp;
            head_valid_next = skid_valid_reg || push;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            list_idx_reg   <= '0;
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            list_idx_reg   <= list_idx_next;
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        if (push && head_valid_reg && !pop && !skid_valid_reg)
            skid_reg <= push_rsp;
    end

    assign rsp_valid  = head_valid_reg;
    assign status     = head_reg.status;
    assign index      = head_reg.index;
    assign entry      = head_reg.entry;
    assign fill_count = head_reg.fill_count;
    assign last       = head_reg.last;

`ifndef SYNTH
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid holds a beat while head is empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("fill count above capacity");

    a_list_blocks_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST) |-> cmd_stall)
        else $error("command accepted during list walk");

    a_list_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LIST && push && list_last) |=> (state_reg == S_IDLE))
        else $error("list walk did not end after last entry");
`endif

endmodule
